FILE: rtl/pvru_pkg.sv
// ----------------------------------------------------------------------------
// pvru_pkg
// Shared constants for the path-vector route update unit.
// ----------------------------------------------------------------------------
package pvru_pkg;

  localparam int unsigned NID_W   = 4;   // node identifier width
  localparam int unsigned ROUTE_W = 64;  // packed next-hop word
  localparam int unsigned COST_W  = 16;  // cost field width on the ports

  localparam logic KIND_LINK = 1'b0;     // link cost change
  localparam logic KIND_VEC  = 1'b1;     // neighbor vector element

endpackage
// ----------------------------------------------------------------------------

FILE: rtl/path_vector_route_update_unit.sv
// ----------------------------------------------------------------------------
// path_vector_route_update_unit
// Path-vector routing table engine for one node with loop-checked recompute.
// ----------------------------------------------------------------------------
// The unit holds every node's cost and route word per destination in one
// synchronous RAM (NODES*NODES entries) and the link costs in registers. A
// link change, or a vector element marked last, starts a recompute; other
// elements are only stored. A recompute visits each destination other than
// self_id, and for each usable neighbor reads one RAM entry and, when the
// candidate beats the current best, walks its route word one hop per cycle.
// Each destination then reads, compares and writes back its own entry and
// loads the result register. The recompute time is set by the single read
// port and the one-hop-per-cycle walk. No input transaction is taken during
// a recompute; a result waits in the output register and stalls the
// sequencer only when the next result is ready before it is taken.
// RAM entries carry valid bits that reset clears; an entry not yet written
// reads as its reset value (diagonal route nibble and zero cost, else zero
// route and infinite cost).
// ----------------------------------------------------------------------------
module path_vector_route_update_unit #(
  parameter int unsigned NODES     = 16,
  parameter int unsigned COST_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  self_id_i,
  // input transactions
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [3:0]  node_i,
  input  logic [3:0]  destination_i,
  input  logic [15:0] cost_i,
  input  logic [63:0] route_word_i,
  input  logic        last_i,
  // result transactions
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  destination_res_o,
  output logic [3:0]  next_hop_o,
  output logic [15:0] path_cost_o,
  output logic        changed_o,
  output logic        final_res_o
);

  localparam int unsigned IDX_W = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int unsigned DEPTH = NODES * NODES;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned RW    = pvru_pkg::ROUTE_W;
  localparam int unsigned NW    = pvru_pkg::NID_W;
  localparam int unsigned MW    = RW + COST_BITS;
  localparam logic [COST_BITS-1:0] COST_INF = {COST_BITS{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE, ST_START, ST_DEST, ST_JSEL, ST_JDAT, ST_WALK, ST_OWN, ST_OWNDAT
  } state_e;

  state_e               state_q, state_d;
  logic [NW-1:0]        self_q;
  logic [COST_BITS-1:0] link_q [NODES];
  logic [DEPTH-1:0]     vld_q;
  logic [IDX_W-1:0]     dst_q, dst_d;
  logic [IDX_W-1:0]     nbr_q, nbr_d;
  logic [COST_BITS-1:0] best_q, best_d;
  logic [RW-1:0]        bw_q, bw_d;
  logic [COST_BITS-1:0] cand_q, cand_d;
  logic [RW-1:0]        cw_q, cw_d;
  logic [NW-1:0]        walk_q, walk_d;
  logic [15:0]          seen_q, seen_d;
  logic                 any_q, any_d;
  logic [IDX_W-1:0]     rrow_q, rcol_q;
  logic                 rvld_q;

  logic                 out_valid_q, out_valid_d;
  logic [3:0]           res_dst_q, res_dst_d;
  logic [3:0]           res_hop_q, res_hop_d;
  logic [COST_BITS-1:0] res_cost_q, res_cost_d;
  logic                 res_chg_q, res_chg_d;
  logic                 res_fin_q, res_fin_d;

  // RAM access
  logic                 we, re;
  logic [AW-1:0]        waddr, raddr;
  logic [MW-1:0]        wdata, rdata;
  logic [IDX_W-1:0]     rrow, rcol;

  // read data with reset value substituted for never-written entries
  logic [RW-1:0]        rd_route;
  logic [COST_BITS-1:0] rd_cost;

  logic                 in_acc;
  logic [COST_BITS-1:0] cost_in;
  logic                 node_ok, dest_ok;
  logic [NW-1:0]        nib;
  logic [COST_BITS-1:0] sum_c;
  logic [RW-1:0]        hop_mask;
  logic                 dst_final;
  logic                 out_free;

  function automatic logic [AW-1:0] addr_of(input logic [IDX_W-1:0] row,
                                            input logic [IDX_W-1:0] col);
    logic [AW+IDX_W:0] a;
    a = (AW+IDX_W+1)'(row) * (AW+IDX_W+1)'(NODES) + (AW+IDX_W+1)'(col);
    return a[AW-1:0];
  endfunction

  function automatic logic [COST_BITS-1:0] sat_add(input logic [COST_BITS-1:0] a,
                                                   input logic [COST_BITS-1:0] b);
    logic [COST_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (a == COST_INF || b == COST_INF || s >= {1'b0, COST_INF}) begin
      return COST_INF;
    end
    return s[COST_BITS-1:0];
  endfunction

  pvru_ram #(
    .WIDTH(MW),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  // clamp the incoming cost to infinity for narrow cost configurations
  always_comb begin
    if (33'(cost_i) > 33'(COST_INF)) begin
      cost_in = COST_INF;
    end else begin
      cost_in = COST_BITS'(cost_i);
    end
  end

  assign node_ok = (5'(node_i) < 5'(NODES));
  assign dest_ok = (5'(destination_i) < 5'(NODES));

  always_comb begin
    if (rvld_q) begin
      rd_route = rdata[MW-1:COST_BITS];
      rd_cost  = rdata[COST_BITS-1:0];
    end else if (rrow_q == rcol_q) begin
      rd_route = RW'(rrow_q) << {rrow_q, 2'b00};
      rd_cost  = '0;
    end else begin
      rd_route = '0;
      rd_cost  = COST_INF;
    end
  end

  assign nib       = cw_q[{walk_q, 2'b00} +: NW];
  assign sum_c     = sat_add(rd_cost, link_q[nbr_q]);
  assign hop_mask  = RW'(4'hF) << {self_q, 2'b00};
  assign dst_final = (dst_q == IDX_W'(NODES - 1)) ||
                     ((dst_q == IDX_W'(NODES - 2)) && (self_q == NW'(NODES - 1)));

  always_comb begin
    state_d     = state_q;
    dst_d       = dst_q;
    nbr_d       = nbr_q;
    best_d      = best_q;
    bw_d        = bw_q;
    cand_d      = cand_q;
    cw_d        = cw_q;
    walk_d      = walk_q;
    seen_d      = seen_q;
    any_d       = any_q;
    out_valid_d = out_valid_q && !out_ready_i;
    res_dst_d   = res_dst_q;
    res_hop_d   = res_hop_q;
    res_cost_d  = res_cost_q;
    res_chg_d   = res_chg_q;
    res_fin_d   = res_fin_q;
    we          = 1'b0;
    waddr       = addr_of(node_i[IDX_W-1:0], destination_i[IDX_W-1:0]);
    wdata       = {route_word_i, cost_in};
    re          = 1'b0;
    rrow        = nbr_q;
    rcol        = dst_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (kind_i == pvru_pkg::KIND_LINK) begin
            state_d = ST_START;
          end else begin
            // store the element in the sender's row
            we = node_ok && dest_ok;
            if (last_i) begin
              state_d = ST_START;
            end
          end
        end
      end
      ST_START: begin
        dst_d = '0;
        any_d = 1'b0;
        if (5'(self_q) < 5'(NODES)) begin
          state_d = ST_DEST;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_DEST: begin
        if (NW'(dst_q) == self_q) begin
          // skip own destination
          if (dst_q == IDX_W'(NODES - 1)) begin
            state_d = ST_IDLE;
          end else begin
            dst_d = dst_q + 1'b1;
          end
        end else begin
          best_d  = COST_INF;
          bw_d    = '0;
          nbr_d   = '0;
          state_d = ST_JSEL;
        end
      end
      ST_JSEL: begin
        if (NW'(nbr_q) == self_q || link_q[nbr_q] == COST_INF) begin
          if (nbr_q == IDX_W'(NODES - 1)) begin
            state_d = ST_OWN;
          end else begin
            nbr_d = nbr_q + 1'b1;
          end
        end else begin
          re      = 1'b1;
          state_d = ST_JDAT;
        end
      end
      ST_JDAT: begin
        cand_d = sum_c;
        cw_d   = rd_route;
        if (sum_c < best_q) begin
          // start the loop check at the candidate neighbor
          walk_d  = NW'(nbr_q);
          seen_d  = 16'(1) << self_q;
          state_d = ST_WALK;
        end else if (nbr_q == IDX_W'(NODES - 1)) begin
          state_d = ST_OWN;
        end else begin
          nbr_d   = nbr_q + 1'b1;
          state_d = ST_JSEL;
        end
      end
      ST_WALK: begin
        if (nib == walk_q || seen_q[walk_q]) begin
          if (nib == walk_q) begin
            best_d = cand_q;
            bw_d   = (cw_q & ~hop_mask) | (RW'(nbr_q) << {self_q, 2'b00});
          end
          if (nbr_q == IDX_W'(NODES - 1)) begin
            state_d = ST_OWN;
          end else begin
            nbr_d   = nbr_q + 1'b1;
            state_d = ST_JSEL;
          end
        end else begin
          seen_d[walk_q] = 1'b1;
          walk_d         = nib;
        end
      end
      ST_OWN: begin
        re      = 1'b1;
        rrow    = self_q[IDX_W-1:0];
        state_d = ST_OWNDAT;
      end
      ST_OWNDAT: begin
        waddr = addr_of(self_q[IDX_W-1:0], dst_q);
        wdata = {bw_q, best_q};
        if (out_free) begin
          // compare, write back and load the result register
          we          = 1'b1;
          any_d       = any_q || (rd_route != bw_q) || (rd_cost != best_q);
          out_valid_d = 1'b1;
          res_dst_d   = 4'(dst_q);
          res_hop_d   = bw_q[{self_q, 2'b00} +: NW];
          res_cost_d  = best_q;
          res_chg_d   = dst_final && any_d;
          res_fin_d   = dst_final;
          if (dst_final) begin
            state_d = ST_IDLE;
          end else begin
            dst_d   = dst_q + 1'b1;
            state_d = ST_DEST;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    raddr = addr_of(rrow, rcol);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      self_q      <= '0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
      any_q       <= 1'b0;
      for (int i = 0; i < NODES; i++) begin
        link_q[i] <= COST_INF;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      any_q       <= any_d;
      if (cfg_valid_i && cfg_ready_o) begin
        self_q <= self_id_i;
      end
      if (in_acc && kind_i == pvru_pkg::KIND_LINK && node_ok) begin
        link_q[node_i[IDX_W-1:0]] <= cost_in;
      end
      if (we) begin
        vld_q[waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dst_q      <= dst_d;
    nbr_q      <= nbr_d;
    best_q     <= best_d;
    bw_q       <= bw_d;
    cand_q     <= cand_d;
    cw_q       <= cw_d;
    walk_q     <= walk_d;
    seen_q     <= seen_d;
    res_dst_q  <= res_dst_d;
    res_hop_q  <= res_hop_d;
    res_cost_q <= res_cost_d;
    res_chg_q  <= res_chg_d;
    res_fin_q  <= res_fin_d;
    if (re) begin
      rrow_q <= rrow;
      rcol_q <= rcol;
      rvld_q <= vld_q[raddr];
    end
  end

  assign out_valid_o       = out_valid_q;
  assign destination_res_o = res_dst_q;
  assign next_hop_o        = res_hop_q;
  assign path_cost_o       = 16'(res_cost_q);
  assign changed_o         = res_chg_q;
  assign final_res_o       = res_fin_q;

`ifndef ASSERT_OFF
  // the walk always treats self as already visited
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WALK |-> seen_q[self_q])
    else $error("self not marked during loop check");

  // an infinite best cost carries no route
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OWN || state_q == ST_OWNDAT) && best_q == COST_INF |-> bw_q == '0)
    else $error("route kept for unreachable destination");

  // changed is reported only on the final result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !final_res_o |-> !changed_o)
    else $error("changed flag on non-final result");

  // no input is taken while a recompute runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> !in_ready_o)
    else $error("input ready during recompute");
`endif

endmodule
// ----------------------------------------------------------------------------

FILE: rtl/pvru_ram.sv
// ----------------------------------------------------------------------------
// pvru_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module pvru_ram #(
  parameter int unsigned WIDTH = 80,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
// ----------------------------------------------------------------------------
